// File: hdl/spam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spam_pkg: shared types and constants
// Operation and status codes, field widths and the control/status structs
// between the sequencer and the sorted term tables.
// ----------------------------------------------------------------------------
package spam_pkg;

    localparam int OPERAND_TERMS_DEF = 8;
    localparam int RESULT_TERMS_DEF  = 64;

    localparam int OP_W   = 3;
    localparam int TCW    = 16;   // loaded coefficient width
    localparam int TEW    = 8;    // loaded exponent width
    localparam int RCW    = 38;   // result coefficient width
    localparam int REW    = 9;    // result exponent width
    localparam int PRW    = 32;   // product width
    localparam int STAT_W = 2;

    localparam logic [OP_W-1:0] OP_LOAD_A = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL    = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVF   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic merge;
        logic clear;
    } t_tbl_ctl;

    typedef struct packed {
        logic busy;
        logic done;
        logic dropped;
    } t_tbl_sts;

endpackage

// File: hdl/spam_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spam_table: sorted term table
// Keeps terms in descending exponent order in a small memory; a merge scans
// for the slot, then adds with saturation into an equal exponent, shifts entries
// up to insert, or shifts them down to remove a zero sum.
// ----------------------------------------------------------------------------
module spam_table import spam_pkg::*; #(
    parameter int DEPTH = OPERAND_TERMS_DEF,
    parameter int EW    = TEW,
    parameter int CW    = TCW,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW   = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_tbl_ctl             i_ctl,
    input  logic signed [EW-1:0] i_exp,
    input  logic signed [CW-1:0] i_coef,
    input  logic        [AW-1:0] i_addr,
    output logic signed [EW-1:0] o_exp,
    output logic signed [CW-1:0] o_coef,
    output logic        [NW-1:0] o_count,
    output t_tbl_sts             o_sts
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_UPRD = 3'd3;
    localparam logic [2:0] S_UPWR = 3'd4;
    localparam logic [2:0] S_DNRD = 3'd5;
    localparam logic [2:0] S_DNWR = 3'd6;

    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    logic signed [EW-1:0] ex_mem [DEPTH];
    logic signed [CW-1:0] co_mem [DEPTH];

    logic [2:0]           r_state, n_state;
    logic [NW-1:0]        r_cnt, n_cnt;
    logic [NW-1:0]        r_i, n_i;
    logic [NW-1:0]        r_k, n_k;
    logic signed [EW-1:0] r_e, n_e;
    logic signed [CW-1:0] r_c, n_c;
    logic                 r_done, n_done;
    logic                 r_drop, n_drop;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [AW-1:0]        w_raddr;
    logic signed [EW-1:0] w_wex;
    logic signed [CW-1:0] w_wco;
    logic signed [CW:0]   w_sum;
    logic signed [CW-1:0] w_sat;
    logic                 w_full;

    assign w_sum  = {o_coef[CW-1], o_coef} + {r_c[CW-1], r_c};
    assign w_full = (r_cnt >= NW'(DEPTH));

    always_comb begin
        if (w_sum[CW] != w_sum[CW-1]) begin
            w_sat = w_sum[CW] ? C_MIN : C_MAX;
        end else begin
            w_sat = w_sum[CW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_k     = r_k;
        n_e     = r_e;
        n_c     = r_c;
        n_done  = 1'b0;
        n_drop  = 1'b0;
        w_we    = 1'b0;
        w_waddr = r_i[AW-1:0];
        w_wex   = r_e;
        w_wco   = r_c;
        w_raddr = i_addr;
        unique case (r_state)
            S_IDLE: begin
                if (i_ctl.clear) begin
                    n_cnt = '0;
                end else if (i_ctl.merge) begin
                    n_e     = i_exp;
                    n_c     = i_coef;
                    n_i     = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                w_raddr = r_i[AW-1:0];
                n_state = S_CMP;
            end
            S_CMP: begin
                w_raddr = r_i[AW-1:0];
                if (r_i >= r_cnt) begin
                    // slot past the last entry
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    if (w_full) begin
                        n_drop = 1'b1;
                    end else begin
                        w_we  = 1'b1;
                        n_cnt = r_cnt + NW'(1);
                    end
                end else if (o_exp > r_e) begin
                    n_i     = r_i + NW'(1);
                    n_state = S_RD;
                end else if (o_exp == r_e) begin
                    if (w_sat == '0) begin
                        n_k     = r_i;
                        n_state = S_DNRD;
                    end else begin
                        w_we    = 1'b1;
                        w_wex   = o_exp;
                        w_wco   = w_sat;
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                    end
                end else if (w_full) begin
                    n_drop  = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_cnt;
                    n_state = S_UPRD;
                end
            end
            S_UPRD: begin
                if (r_k == r_i) begin
                    w_we    = 1'b1;
                    n_cnt   = r_cnt + NW'(1);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    w_raddr = AW'(r_k - NW'(1));
                    n_state = S_UPWR;
                end
            end
            S_UPWR: begin
                w_we    = 1'b1;
                w_waddr = r_k[AW-1:0];
                w_wex   = o_exp;
                w_wco   = o_coef;
                n_k     = r_k - NW'(1);
                n_state = S_UPRD;
            end
            S_DNRD: begin
                if ((r_k + NW'(1)) >= r_cnt) begin
                    n_cnt   = r_cnt - NW'(1);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    w_raddr = AW'(r_k + NW'(1));
                    n_state = S_DNWR;
                end
            end
            S_DNWR: begin
                w_we    = 1'b1;
                w_waddr = r_k[AW-1:0];
                w_wex   = o_exp;
                w_wco   = o_coef;
                n_k     = r_k + NW'(1);
                n_state = S_DNRD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            ex_mem[w_waddr] <= w_wex;
            co_mem[w_waddr] <= w_wco;
        end
        o_exp  <= ex_mem[w_raddr];
        o_coef <= co_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
            r_drop  <= n_drop;
        end
        r_i <= n_i;
        r_k <= n_k;
        r_e <= n_e;
        r_c <= n_c;
    end

    assign o_count      = r_cnt;
    assign o_sts.busy    = (r_state != S_IDLE);
    assign o_sts.done    = r_done;
    assign o_sts.dropped = r_drop;

endmodule

// File: hdl/sparse_polynomial_add_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_polynomial_add_multiply: sparse polynomial adder and multiplier
// Loads terms into two sorted operand tables and builds a merged add or
// multiply result table, then streams the result terms out.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the item is fully handled. A load walks its operand table, passing entries
// until it finds the slot and shifting entries to insert or remove one.
// Add and multiply feed every term (or every nonzero product) one after the
// other through the result table's merge unit, which likewise scans and
// shifts entries. Results follow one by one on o_strobe; the receiver cannot
// stall, so each result is valid for exactly one cycle. Clear and unused
// codes never raise busy.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_multiply import spam_pkg::*; #(
    parameter int OPERAND_TERMS = OPERAND_TERMS_DEF,
    parameter int RESULT_TERMS  = RESULT_TERMS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic        [OP_W-1:0]   i_operation,
    input  logic signed [TCW-1:0]    i_term_coefficient,
    input  logic signed [TEW-1:0]    i_term_exponent,
    output logic                     o_strobe,
    output logic signed [RCW-1:0]    o_result_coefficient,
    output logic signed [REW-1:0]    o_result_exponent,
    output logic                     o_last_term,
    output logic        [STAT_W-1:0] o_status
);

    localparam int OAW = (OPERAND_TERMS > 1) ? $clog2(OPERAND_TERMS) : 1;
    localparam int ONW = $clog2(OPERAND_TERMS + 1);
    localparam int RAW = (RESULT_TERMS > 1) ? $clog2(RESULT_TERMS) : 1;
    localparam int RNW = $clog2(RESULT_TERMS + 1);

    // sequencer states
    localparam logic [4:0] T_IDLE = 5'd0;
    localparam logic [4:0] T_LDGO = 5'd1;
    localparam logic [4:0] T_LDWT = 5'd2;
    localparam logic [4:0] T_ARD  = 5'd3;
    localparam logic [4:0] T_AGO  = 5'd4;
    localparam logic [4:0] T_AWT  = 5'd5;
    localparam logic [4:0] T_BRD  = 5'd6;
    localparam logic [4:0] T_BGO  = 5'd7;
    localparam logic [4:0] T_BWT  = 5'd8;
    localparam logic [4:0] T_MA   = 5'd9;
    localparam logic [4:0] T_MB   = 5'd10;
    localparam logic [4:0] T_MMUL = 5'd11;
    localparam logic [4:0] T_MGO  = 5'd12;
    localparam logic [4:0] T_MWT  = 5'd13;
    localparam logic [4:0] T_EDEC = 5'd14;
    localparam logic [4:0] T_ERD  = 5'd15;
    localparam logic [4:0] T_EOUT = 5'd16;

    logic [4:0]            r_state, n_state;
    logic [OP_W-1:0]       r_op, n_op;
    logic signed [TCW-1:0] r_coef, n_coef;
    logic signed [TEW-1:0] r_exp, n_exp;
    logic [ONW-1:0]        r_i, n_i;
    logic [ONW-1:0]        r_j, n_j;
    logic [RNW-1:0]        r_k, n_k;
    logic signed [PRW-1:0] r_p, n_p;
    logic                  r_ovf, n_ovf;
    logic                  r_drop, n_drop;

    logic                  r_strobe, n_strobe;
    logic signed [RCW-1:0] r_res_coef, n_res_coef;
    logic signed [REW-1:0] r_res_exp, n_res_exp;
    logic                  r_last, n_last;
    logic [STAT_W-1:0]     r_status, n_status;

    // table ports
    t_tbl_ctl              w_a_ctl, w_b_ctl, w_s_ctl;
    t_tbl_sts              w_a_sts, w_b_sts, w_s_sts;
    logic signed [TEW-1:0] w_a_ex, w_b_ex;
    logic signed [TCW-1:0] w_a_co, w_b_co;
    logic [ONW-1:0]        w_a_cnt, w_b_cnt;
    logic signed [REW-1:0] w_s_ex, w_s_in_ex;
    logic signed [RCW-1:0] w_s_co, w_s_in_co;
    logic [RNW-1:0]        w_s_cnt;
    logic [STAT_W-1:0]     w_run_status;

    spam_table #(.DEPTH(OPERAND_TERMS), .EW(TEW), .CW(TCW)) u_tbl_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_a_ctl),
        .i_exp   (r_exp),
        .i_coef  (r_coef),
        .i_addr  (r_i[OAW-1:0]),
        .o_exp   (w_a_ex),
        .o_coef  (w_a_co),
        .o_count (w_a_cnt),
        .o_sts   (w_a_sts)
    );

    spam_table #(.DEPTH(OPERAND_TERMS), .EW(TEW), .CW(TCW)) u_tbl_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_b_ctl),
        .i_exp   (r_exp),
        .i_coef  (r_coef),
        .i_addr  (r_j[OAW-1:0]),
        .o_exp   (w_b_ex),
        .o_coef  (w_b_co),
        .o_count (w_b_cnt),
        .o_sts   (w_b_sts)
    );

    spam_table #(.DEPTH(RESULT_TERMS), .EW(REW), .CW(RCW)) u_tbl_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_s_ctl),
        .i_exp   (w_s_in_ex),
        .i_coef  (w_s_in_co),
        .i_addr  (r_k[RAW-1:0]),
        .o_exp   (w_s_ex),
        .o_coef  (w_s_co),
        .o_count (w_s_cnt),
        .o_sts   (w_s_sts)
    );

    assign w_run_status = (r_ovf || r_drop) ? ST_OVF : ST_OK;

    // term fed into the result table: operand term for add, product for multiply
    always_comb begin
        case (r_state)
            T_AGO: begin
                w_s_in_ex = REW'(w_a_ex);
                w_s_in_co = RCW'(w_a_co);
            end
            T_BGO: begin
                w_s_in_ex = REW'(w_b_ex);
                w_s_in_co = RCW'(w_b_co);
            end
            default: begin
                w_s_in_ex = REW'(w_a_ex) + REW'(w_b_ex);
                w_s_in_co = RCW'(r_p);
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_coef     = r_coef;
        n_exp      = r_exp;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_p        = r_p;
        n_ovf      = r_ovf;
        n_drop     = r_drop;
        n_strobe   = 1'b0;
        n_res_coef = r_res_coef;
        n_res_exp  = r_res_exp;
        n_last     = r_last;
        n_status   = r_status;
        w_a_ctl    = '0;
        w_b_ctl    = '0;
        w_s_ctl    = '0;
        unique case (r_state)
            T_IDLE: begin
                if (start) begin
                    n_op   = i_operation;
                    n_coef = i_term_coefficient;
                    n_exp  = i_term_exponent;
                    n_i    = '0;
                    n_j    = '0;
                    n_drop = 1'b0;
                    unique case (i_operation) inside
                        OP_LOAD_A, OP_LOAD_B: begin
                            // zero terms never enter a sparse table
                            if (i_term_coefficient != '0) begin
                                n_state = T_LDGO;
                            end
                        end
                        OP_ADD: begin
                            w_s_ctl.clear = 1'b1;
                            n_state       = T_ARD;
                        end
                        OP_MUL: begin
                            w_s_ctl.clear = 1'b1;
                            n_state       = T_MA;
                        end
                        OP_CLEAR: begin
                            w_a_ctl.clear = 1'b1;
                            w_b_ctl.clear = 1'b1;
                            n_ovf         = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            T_LDGO: begin
                w_a_ctl.merge = (r_op == OP_LOAD_A);
                w_b_ctl.merge = (r_op == OP_LOAD_B);
                n_state       = T_LDWT;
            end
            T_LDWT: begin
                if (w_a_sts.done || w_b_sts.done) begin
                    if (w_a_sts.dropped || w_b_sts.dropped) begin
                        n_ovf = 1'b1;
                    end
                    n_state = T_IDLE;
                end
            end
            // add: all of A, then all of B
            T_ARD: begin
                n_state = (r_i >= w_a_cnt) ? T_BRD : T_AGO;
            end
            T_AGO: begin
                w_s_ctl.merge = 1'b1;
                n_state       = T_AWT;
            end
            T_AWT: begin
                if (w_s_sts.done) begin
                    n_drop  = r_drop | w_s_sts.dropped;
                    n_i     = r_i + ONW'(1);
                    n_state = T_ARD;
                end
            end
            T_BRD: begin
                n_state = (r_j >= w_b_cnt) ? T_EDEC : T_BGO;
            end
            T_BGO: begin
                w_s_ctl.merge = 1'b1;
                n_state       = T_BWT;
            end
            T_BWT: begin
                if (w_s_sts.done) begin
                    n_drop  = r_drop | w_s_sts.dropped;
                    n_j     = r_j + ONW'(1);
                    n_state = T_BRD;
                end
            end
            // multiply: outer walk over A, inner walk over B
            T_MA: begin
                n_j     = '0;
                n_state = (r_i >= w_a_cnt) ? T_EDEC : T_MB;
            end
            T_MB: begin
                if (r_j >= w_b_cnt) begin
                    n_i     = r_i + ONW'(1);
                    n_state = T_MA;
                end else begin
                    n_state = T_MMUL;
                end
            end
            T_MMUL: begin
                n_p     = PRW'(w_a_co) * PRW'(w_b_co);
                n_state = T_MGO;
            end
            T_MGO: begin
                if (r_p == '0) begin
                    n_j     = r_j + ONW'(1);
                    n_state = T_MB;
                end else begin
                    w_s_ctl.merge = 1'b1;
                    n_state       = T_MWT;
                end
            end
            T_MWT: begin
                if (w_s_sts.done) begin
                    n_drop  = r_drop | w_s_sts.dropped;
                    n_j     = r_j + ONW'(1);
                    n_state = T_MB;
                end
            end
            T_EDEC: begin
                n_k = '0;
                if (w_s_cnt == '0) begin
                    // empty result: a single flagged item
                    n_strobe   = 1'b1;
                    n_res_coef = '0;
                    n_res_exp  = '0;
                    n_last     = 1'b1;
                    n_status   = ST_EMPTY;
                    n_state    = T_IDLE;
                end else begin
                    n_state = T_ERD;
                end
            end
            T_ERD: begin
                n_state = T_EOUT;
            end
            T_EOUT: begin
                n_strobe   = 1'b1;
                n_res_coef = w_s_co;
                n_res_exp  = w_s_ex;
                n_last     = ((r_k + RNW'(1)) >= w_s_cnt);
                n_status   = w_run_status;
                n_k        = r_k + RNW'(1);
                n_state    = ((r_k + RNW'(1)) >= w_s_cnt) ? T_IDLE : T_ERD;
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovf    <= n_ovf;
            r_strobe <= n_strobe;
        end
        r_op       <= n_op;
        r_coef     <= n_coef;
        r_exp      <= n_exp;
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_p        <= n_p;
        r_drop     <= n_drop;
        r_res_coef <= n_res_coef;
        r_res_exp  <= n_res_exp;
        r_last     <= n_last;
        r_status   <= n_status;
    end

    assign busy                 = (r_state != T_IDLE);
    assign o_strobe             = r_strobe;
    assign o_result_coefficient = r_res_coef;
    assign o_result_exponent    = r_res_exp;
    assign o_last_term          = r_last;
    assign o_status             = r_status;

    // operand tables never hold more than their depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_a_cnt <= ONW'(OPERAND_TERMS)) && (w_b_cnt <= ONW'(OPERAND_TERMS)))
        else $error("operand count beyond table depth");

    // the last item of a run ends the stream
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_term) |=> !o_strobe)
        else $error("result after last item");

    // an empty-result item is always the last one
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_EMPTY)) |-> o_last_term)
        else $error("empty status without last flag");

endmodule
